// File: rtl/core/blir_pkg.sv
// ============================================================================
// blir_pkg
// Shared types and constants for the bounded ordered list.
// ============================================================================
package blir_pkg;

    localparam int DEPTH      = 16;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W    = $clog2(DEPTH + 1);
    localparam int VALUE_W    = 32;
    localparam int POS_W      = 8;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int ECOUNT_W   = 9;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;

    // operation codes
    localparam logic [FUNC_W-1:0] OP_INS_FRONT = 2'd0;
    localparam logic [FUNC_W-1:0] OP_INS_BACK  = 2'd1;
    localparam logic [FUNC_W-1:0] OP_REM_FRONT = 2'd2;
    localparam logic [FUNC_W-1:0] OP_REM_POS   = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BEYOND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    // command broadcast to every cell for one item
    typedef struct packed {
        logic                en;     // item accepted and operation succeeds
        logic [FUNC_W-1:0]   op;
        logic [POS_W-1:0]    pos;    // removal index, zero for remove front
        logic [COUNT_W-1:0]  count;  // occupancy before the operation
        logic [VALUE_W-1:0]  value;
    } cell_cmd_t;

endpackage

// File: rtl/core/blir_cell.sv
// ============================================================================
// blir_cell
// One list slot: holds an entry and shifts with its neighbors.
// ============================================================================
module blir_cell
(
    input  logic                        clk,
    input  blir_pkg::cell_cmd_t         cmd,
    input  logic [blir_pkg::IDX_W-1:0]  idx,
    input  logic [blir_pkg::VALUE_W-1:0] left_data,
    input  logic [blir_pkg::VALUE_W-1:0] right_data,
    output logic [blir_pkg::VALUE_W-1:0] data,
    output logic [blir_pkg::VALUE_W-1:0] hit_data
);
    import blir_pkg::*;

    logic [VALUE_W-1:0] entry_reg;
    logic [VALUE_W-1:0] entry_next;
    logic               at_pos;
    logic               past_pos;
    logic               at_tail;

    assign at_pos   = (POS_W'(idx) == cmd.pos);
    assign past_pos = (POS_W'(idx) >= cmd.pos);
    assign at_tail  = (COUNT_W'(idx) == cmd.count);

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.op)
            OP_INS_FRONT:
            begin
                entry_next = (idx == '0) ? cmd.value : left_data;
            end
            OP_INS_BACK:
            begin
                if (at_tail)
                begin
                    entry_next = cmd.value;
                end
            end
            OP_REM_FRONT, OP_REM_POS:
            begin
                // close the gap: everything at or behind the slot moves forward
                if (past_pos)
                begin
                    entry_next = right_data;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.en)
        begin
            entry_reg <= entry_next;
        end
    end

    assign data     = entry_reg;
    assign hit_data = at_pos ? entry_reg : '0;

endmodule

// File: rtl/core/bounded_list_insert_remove.sv
// ============================================================================
// bounded_list_insert_remove
// Ordered list of up to DEPTH signed values kept in a row of shifting cells.
// ============================================================================
//  channel | dir | fields (low bit first)
//  s_*     | in  | func[1:0], item_value[33:2], position[41:34], zero pad
//  m_*     | out | status[1:0], removed_value[33:2], entry_count[42:34], pad
//
//  One item per clock while no result is stalled: every cell shifts or holds in
//  parallel, and the item's result is registered in the output register.
//  A new item is taken while the held result is being taken.
//  rst_n clears the count and the output valid; entries need no reset.
//  A stalled result holds s_tready low until m_tready rises.
// ============================================================================
module bounded_list_insert_remove
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // func, item_value, position
    input  logic [blir_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status, removed_value, entry_count
    output logic [blir_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import blir_pkg::*;

    logic [FUNC_W-1:0]   func;
    logic [VALUE_W-1:0]  item_value;
    logic [POS_W-1:0]    position;

    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic                out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic                accept;
    logic                is_insert;
    logic                ok;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  removed_value;
    logic [VALUE_W-1:0]  hit_or;
    cell_cmd_t           cmd;

    logic [VALUE_W-1:0]  cell_data [DEPTH];
    logic [VALUE_W-1:0]  cell_hit  [DEPTH];

    assign func       = s_tdata[FUNC_W-1:0];
    assign item_value = s_tdata[FUNC_W +: VALUE_W];
    assign position   = s_tdata[FUNC_W+VALUE_W +: POS_W];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign is_insert = func inside {OP_INS_FRONT, OP_INS_BACK};

    always_comb
    begin
        status = ST_OK;
        if (is_insert)
        begin
            if (count_reg == COUNT_W'(DEPTH))
            begin
                status = ST_FULL;
            end
        end
        else if (count_reg == '0)
        begin
            status = ST_EMPTY;
        end
        else if ((func == OP_REM_POS) && ({1'b0, position} >= ECOUNT_W'(count_reg)))
        begin
            status = ST_BEYOND;
        end
    end

    assign ok = (status == ST_OK);

    always_comb
    begin
        cmd.en    = accept && ok;
        cmd.op    = func;
        cmd.pos   = (func == OP_REM_POS) ? position : '0;
        cmd.count = count_reg;
        cmd.value = item_value;
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [VALUE_W-1:0] left_d;
            logic [VALUE_W-1:0] right_d;
            if (g == 0)
            begin : g_first
                assign left_d = item_value;
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_last
                assign right_d = cell_data[g];
            end
            else
            begin : g_mid_r
                assign right_d = cell_data[g+1];
            end

            blir_cell u_cell
            (
                .clk        (clk),
                .cmd        (cmd),
                .idx        (IDX_W'(g)),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[g]),
                .hit_data   (cell_hit[g])
            );
        end
    endgenerate

    // only the addressed cell drives a nonzero hit
    always_comb
    begin
        hit_or = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            hit_or = hit_or | cell_hit[i];
        end
    end

    assign removed_value = (ok && !is_insert) ? hit_or : '0;

    always_comb
    begin
        count_next = count_reg;
        if (ok)
        begin
            count_next = is_insert ? (count_reg + COUNT_W'(1)) : (count_reg - COUNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= OUT_DATA_W'({ECOUNT_W'(count_next), removed_value, status});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: rtl/core/blir_checker.sv
// ============================================================================
// blir_checker
// Port-level checks for the bounded list, bound to the top level.
// ============================================================================
module blir_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [blir_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [blir_pkg::OUT_DATA_W-1:0] m_tdata
);
    import blir_pkg::*;

    logic [STATUS_W-1:0] st;
    logic [VALUE_W-1:0]  rem;
    logic [ECOUNT_W-1:0] cnt;

    assign st  = m_tdata[STATUS_W-1:0];
    assign rem = m_tdata[STATUS_W +: VALUE_W];
    assign cnt = m_tdata[STATUS_W+VALUE_W +: ECOUNT_W];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted item gave no result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> cnt <= ECOUNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (st != ST_OK) |-> rem == '0)
        else $error("failed operation returned a value");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && (st == ST_OK) ##1 m_tvalid && (st != ST_OK)
        |-> cnt == $past(cnt))
        else $error("failed operation changed the count");

endmodule

bind bounded_list_insert_remove blir_checker u_blir_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/list_checker.sv
// ============================================================================
// list_checker
// Tracks the bounded list from both streams and checks every result.
// ============================================================================
// Each item taken on the s side is applied to a shadow list, and the expected
// status, removed value and count are queued. Each result taken on the m side
// is compared field by field with the oldest queued entry.
// ============================================================================
module list_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // func, item_value, position
    input  logic [blir_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // status, removed_value, entry_count
    input  logic [blir_pkg::OUT_DATA_W-1:0] m_tdata,
    output int                              fail_count,
    output int                              pending,
    output int                              list_size,
    output int                              items_taken,
    output int                              results_seen,
    output int                              full_hits,
    output int                              empty_hits,
    output int                              beyond_hits
);
    import blir_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  removed;
        logic [ECOUNT_W-1:0] count;
    } list_result_t;

    logic [VALUE_W-1:0] shadow_list[$];   // index 0 is the front
    list_result_t       expected_results[$];

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on result %0d: %s got %0h, expected %0h",
                 results_seen, what, got, want);
        fail_count++;
    endtask

    function automatic list_result_t apply_list_op(input logic [FUNC_W-1:0] op,
                                                   input logic [VALUE_W-1:0] val,
                                                   input logic [POS_W-1:0] pos);
        list_result_t r;
        r.status  = ST_OK;
        r.removed = '0;
        case (op)
            OP_INS_FRONT:
                if (shadow_list.size() >= DEPTH) r.status = ST_FULL;
                else shadow_list.push_front(val);
            OP_INS_BACK:
                if (shadow_list.size() >= DEPTH) r.status = ST_FULL;
                else shadow_list.push_back(val);
            OP_REM_FRONT:
                if (shadow_list.size() == 0) r.status = ST_EMPTY;
                else r.removed = shadow_list.pop_front();
            default:
                if (shadow_list.size() == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else if (int'(pos) >= shadow_list.size())
                begin
                    r.status = ST_BEYOND;
                end
                else
                begin
                    r.removed = shadow_list[pos];
                    shadow_list.delete(pos);
                end
        endcase
        r.count = ECOUNT_W'(shadow_list.size());
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        list_result_t want;
        list_result_t got;
        if (!rst_n)
        begin
            shadow_list.delete();
            expected_results.delete();
            fail_count   = 0;
            pending      = 0;
            list_size    = 0;
            items_taken  = 0;
            results_seen = 0;
            full_hits    = 0;
            empty_hits   = 0;
            beyond_hits  = 0;
        end
        else
        begin
            // result side first: a result taken at this edge belongs to an older item
            if (m_tvalid && m_tready)
            begin
                got.status  = m_tdata[1:0];
                got.removed = m_tdata[33:2];
                got.count   = m_tdata[42:34];
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result", 64'(got), '0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.removed !== want.removed)
                        report_mismatch("removed_value", 64'(got.removed),
                                        64'(want.removed));
                    if (got.count !== want.count)
                        report_mismatch("entry_count", 64'(got.count), 64'(want.count));
                end
                results_seen++;
            end
            if (s_tvalid && s_tready)
            begin
                want = apply_list_op(s_tdata[1:0], s_tdata[33:2], s_tdata[41:34]);
                case (want.status)
                    ST_FULL:   full_hits++;
                    ST_EMPTY:  empty_hits++;
                    ST_BEYOND: beyond_hits++;
                    default: ;
                endcase
                expected_results.push_back(want);
                items_taken++;
            end
            pending   = expected_results.size();
            list_size = shadow_list.size();
        end
    end

endmodule

// File: tb/testbench.sv
// ============================================================================
// testbench
// Stimulus and verdict for bounded_list_insert_remove.
// ============================================================================
// A directed pass walks the empty, full and beyond-end cases with extreme
// values, then biased random phases push the list between empty and full
// under random source gaps and sink stalls. list_checker does the checking.
// ============================================================================
module testbench;
    import blir_pkg::*;

    localparam int RANDOM_ITEMS = 1700;
    localparam int PHASE_LEN    = 100;
    localparam int STALL_LIMIT  = 2000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;    // func, item_value, position
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;    // status, removed_value, entry_count

    int  fail_count;
    int  pending;
    int  list_size;
    int  items_taken;
    int  results_seen;
    int  full_hits;
    int  empty_hits;
    int  beyond_hits;
    int  quiet_cycles;
    bit  no_idle;

    bounded_list_insert_remove u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    list_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .list_size    (list_size),
        .items_taken  (items_taken),
        .results_seen (results_seen),
        .full_hits    (full_hits),
        .empty_hits   (empty_hits),
        .beyond_hits  (beyond_hits)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // called at a falling edge, returns at the falling edge after the handshake
    task automatic send_item(input logic [FUNC_W-1:0] op, input logic [VALUE_W-1:0] val,
                             input logic [POS_W-1:0] pos);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, pos, val, op};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // result sink: one random stall per result
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    // watchdog: cycles in which neither channel moves an item
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int               bias;
        int               roll;
        logic [FUNC_W-1:0] op;
        logic [VALUE_W-1:0] val;
        logic [POS_W-1:0]  pos;

        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        no_idle      = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // removals from an empty list, then extreme values
        send_item(OP_REM_FRONT, 32'h0000_0000, 8'h00);
        send_item(OP_REM_POS,   32'hFFFF_FFFF, 8'hFF);
        send_item(OP_INS_FRONT, 32'h7FFF_FFFF, 8'hFF);
        send_item(OP_INS_BACK,  32'h8000_0000, 8'h00);
        send_item(OP_INS_FRONT, 32'h0000_0000, 8'h00);
        send_item(OP_INS_BACK,  32'hFFFF_FFFF, 8'hAA);
        // positions past and at the end, then last, middle and zero
        send_item(OP_REM_POS,   32'h0000_0000, 8'hFF);
        send_item(OP_REM_POS,   32'h0000_0000, 8'd4);
        send_item(OP_REM_POS,   32'h0000_0000, 8'd3);
        send_item(OP_REM_POS,   32'h0000_0000, 8'd1);
        send_item(OP_REM_POS,   32'h0000_0000, 8'd0);
        send_item(OP_REM_FRONT, 32'h5555_5555, 8'h55);
        // fill up, overflow on both ends, drop the last entry
        for (int i = 0; i < DEPTH; i++)
            send_item(i[0] ? OP_INS_BACK : OP_INS_FRONT, $urandom,
                      POS_W'($urandom_range(0, 255)));
        send_item(OP_INS_FRONT, 32'h1234_5678, 8'h00);
        send_item(OP_INS_BACK,  32'h8765_4321, 8'hFF);
        send_item(OP_REM_POS,   32'h0000_0000, POS_W'(DEPTH - 1));
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_LEN == 0)
            begin
                // 0 grows the list, 1 shrinks it, 2 keeps it balanced
                bias    = (n / PHASE_LEN) % 3;
                no_idle = ((n / PHASE_LEN) % 4 == 3);
                if ((n / PHASE_LEN) % 5 == 4)
                    drain_results();
            end
            roll = $urandom_range(0, 99);
            if (roll < ((bias == 0) ? 75 : (bias == 1) ? 25 : 50))
                op = $urandom_range(0, 1) ? OP_INS_BACK : OP_INS_FRONT;
            else
                op = ($urandom_range(0, 9) < 6) ? OP_REM_POS : OP_REM_FRONT;
            roll = $urandom_range(0, 9);
            if (op == OP_REM_POS && roll < 7 && list_size > 0)
                pos = POS_W'($urandom_range(0, list_size - 1));
            else if (op == OP_REM_POS && roll == 7)
                pos = POS_W'(list_size);
            else
                pos = POS_W'($urandom_range(0, 255));
            roll = $urandom_range(0, 9);
            val  = (roll == 0) ? 32'h7FFF_FFFF : (roll == 1) ? 32'h8000_0000 : $urandom;
            send_item(op, val, pos);
        end

        drain_results();
        repeat (4) @(negedge clk);
        $display("%0d list operations sent, %0d results compared", items_taken,
                 results_seen);
        $display("refused when full %0d, when empty %0d, position past end %0d",
                 full_hits, empty_hits, beyond_hits);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: files.f
rtl/core/blir_pkg.sv
rtl/core/blir_cell.sv
rtl/core/bounded_list_insert_remove.sv
rtl/core/blir_checker.sv
tb/list_checker.sv
tb/testbench.sv
